@@ src/pcu_pkg.sv @@
// pcu_pkg: shared types and constants for the permutation / combination unit
// no dependencies

package pcu_pkg;

    localparam int FieldW = 31;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INVALID  = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    localparam logic CMD_PERM = 1'b0;
    localparam logic CMD_COMB = 1'b1;

endpackage

@@ src/pcu_div.sv @@
// pcu_div: restoring unsigned divider, one quotient bit per cycle
// standalone, used by permutation_combination_unit

module pcu_div #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CntW = $clog2(W + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_q, n_q;
    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_d, n_d;
    logic [W:0]      rem_sh;
    logic [W:0]      diff;

    assign rem_sh = {r_rem, r_q[W-1]};
    assign diff   = rem_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[W-1:0];
                n_q   = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ src/permutation_combination_unit.sv @@
// permutation_combination_unit: P(n,k) and C(n,k) with exact overflow check
// depends on pcu_pkg and pcu_div
// an overflowing product step or invalid operands end the item early with that status
// one item at a time, ready only when idle: next transfer in the cycle after the result loads
// reset: synchronous active low, returns the sequencer to idle with no result pending

module permutation_combination_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // n_value[30:0], k_value[61:31], zero pad
    input  logic        i_s_tuser,   // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result_value[30:0], zero pad
    output logic [1:0]  o_m_tuser    // status
);

    localparam int FW   = pcu_pkg::FieldW;
    localparam int LimW = (DATA_WIDTH - 1 < FW) ? DATA_WIDTH - 1 : FW;
    localparam int MulW = LimW + FW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic             r_cmd, n_cmd;
    logic             r_fact, n_fact;
    logic [FW-1:0]    r_k, n_k;
    logic [FW-1:0]    r_term, n_term;
    logic [FW-1:0]    r_cnt, n_cnt;
    logic [LimW-1:0]  r_prod, n_prod;
    logic [LimW-1:0]  r_perm, n_perm;
    logic [MulW-1:0]  r_mul, n_mul;
    logic [FW-1:0]    r_res, n_res;
    pcu_pkg::t_status r_sts, n_sts;
    logic             r_out_valid, n_out_valid;
    logic [FW-1:0]    r_out_res, n_out_res;
    pcu_pkg::t_status r_out_sts, n_out_sts;

    logic             div_start;
    logic             div_done;
    logic [LimW-1:0]  div_q;
    logic [FW-1:0]    in_n;
    logic [FW-1:0]    in_k;
    logic             s_xfer;

    assign in_n   = i_s_tdata[FW-1:0];
    assign in_k   = i_s_tdata[2*FW-1:FW];
    assign s_xfer = i_s_tvalid && o_s_tready;

    pcu_div #(
        .W(LimW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_perm),
        .i_divisor  (r_prod),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fact      = r_fact;
        n_k         = r_k;
        n_term      = r_term;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_perm      = r_perm;
        n_mul       = r_mul;
        n_res       = r_res;
        n_sts       = r_sts;
        n_out_res   = r_out_res;
        n_out_sts   = r_out_sts;
        n_out_valid = r_out_valid && !i_m_tready;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_cmd  = i_s_tuser;
                    n_k    = in_k;
                    n_term = in_n;
                    n_cnt  = in_k;
                    n_prod = LimW'(1);
                    n_fact = 1'b0;
                    if (in_n == '0 || in_k > in_n) begin
                        n_res   = '0;
                        n_sts   = pcu_pkg::ST_INVALID;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (r_cnt == '0) begin
                    if (!r_fact) begin
                        if (r_cmd == pcu_pkg::CMD_PERM) begin
                            n_res   = FW'(r_prod);
                            n_sts   = pcu_pkg::ST_OK;
                            n_state = S_DONE;
                        end else begin
                            n_perm = r_prod;
                            n_prod = LimW'(1);
                            n_term = r_k;
                            n_cnt  = r_k;
                            n_fact = 1'b1;
                        end
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else begin
                    n_mul   = r_prod * r_term;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_mul[MulW-1:LimW] != '0) begin
                    n_res   = '0;
                    n_sts   = pcu_pkg::ST_OVERFLOW;
                    n_state = S_DONE;
                end else begin
                    n_prod  = r_mul[LimW-1:0];
                    n_term  = r_term - 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_STEP;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = FW'(div_q);
                    n_sts   = pcu_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_sts   = r_sts;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_fact    <= n_fact;
        r_k       <= n_k;
        r_term    <= n_term;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        r_perm    <= n_perm;
        r_mul     <= n_mul;
        r_res     <= n_res;
        r_sts     <= n_sts;
        r_out_res <= n_out_res;
        r_out_sts <= n_out_sts;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_res};
    assign o_m_tuser  = r_out_sts;

endmodule

@@ bench/pcu_checker.sv @@
`timescale 1ns / 1ps
// pcu_checker: scoreboard for permutation_combination_unit, predicts P(n,k) / C(n,k)
// and status for every request transfer and compares each result transfer in order
// depends on pcu_pkg

module pcu_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // n_value[30:0], k_value[61:31], zero pad
    input  logic        i_s_tuser,   // command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // result_value[30:0], zero pad
    input  logic [1:0]  i_m_tuser,   // status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_ok_count,
    output int          o_invalid_count,
    output int          o_overflow_count
);

    typedef struct packed {
        logic [pcu_pkg::FieldW-1:0] count;
        pcu_pkg::t_status           status;
    } t_count_result;

    t_count_result expected_counts[$];

    function automatic logic [63:0] count_limit();
        logic [63:0] lim;
        if (DATA_WIDTH >= 32) begin
            lim = 64'h7FFF_FFFF;
        end else begin
            lim = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
        end
        return lim;
    endfunction

    // top*(top-1)*... for cnt factors, false when a partial product passes lim
    function automatic logic falling_product(input logic [63:0] top, input logic [63:0] cnt,
                                             input logic [63:0] lim,
                                             output logic [63:0] prod);
        logic [63:0] term;
        logic [63:0] left;
        prod = 64'd1;
        term = top;
        left = cnt;
        while (left > 0 && term > 0) begin
            if (prod > lim / term) return 1'b0;
            prod = prod * term;
            term = term - 64'd1;
            left = left - 64'd1;
        end
        return 1'b1;
    endfunction

    function automatic t_count_result predict_count(input logic cmd,
                                                    input logic [pcu_pkg::FieldW-1:0] n,
                                                    input logic [pcu_pkg::FieldW-1:0] k);
        t_count_result r;
        logic [63:0] lim;
        logic [63:0] perm;
        logic [63:0] fact;
        lim = count_limit();
        r.count = '0;
        r.status = pcu_pkg::ST_OK;
        if (n == 0 || k > n) begin
            r.status = pcu_pkg::ST_INVALID;
        end else if (!falling_product(64'(n), 64'(k), lim, perm)) begin
            r.status = pcu_pkg::ST_OVERFLOW;
        end else if (cmd == pcu_pkg::CMD_PERM) begin
            r.count = perm[pcu_pkg::FieldW-1:0];
        end else if (!falling_product(64'(k), 64'(k), lim, fact) || fact == 0) begin
            r.status = pcu_pkg::ST_OVERFLOW;
        end else begin
            r.count = 31'(perm / fact);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_count_result want;
        t_count_result got;
        if (!i_rst_n) begin
            expected_counts.delete();
            o_fail_count     <= 0;
            o_pending        <= 0;
            o_ok_count       <= 0;
            o_invalid_count  <= 0;
            o_overflow_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = predict_count(i_s_tuser, i_s_tdata[30:0], i_s_tdata[61:31]);
                expected_counts.push_back(want);
                case (want.status)
                    pcu_pkg::ST_OK:      o_ok_count <= o_ok_count + 1;
                    pcu_pkg::ST_INVALID: o_invalid_count <= o_invalid_count + 1;
                    default:             o_overflow_count <= o_overflow_count + 1;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.count = i_m_tdata[pcu_pkg::FieldW-1:0];
                got.status = i_m_tuser;
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected result transfer, count %0d status %0d",
                             $time, got.count, got.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_counts.pop_front();
                    if (want.count !== got.count || want.status !== got.status) begin
                        $display({"%0t: mismatch, expected count %0d status %0d,",
                                  " got count %0d status %0d"},
                                 $time, want.count, want.status, got.count, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_counts.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for permutation_combination_unit
// depends on pcu_pkg, permutation_combination_unit and pcu_checker

module tb_top;

    localparam int QuietLimit = 4000;
    localparam int TailCycles = 200;
    localparam int RandomPerPhase = 225;
    localparam logic [30:0] NMax = 31'h7FFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = pcu_pkg::CMD_PERM;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int ok_count;
    int invalid_count;
    int overflow_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int perm_sent = 0;
    int comb_sent = 0;

    permutation_combination_unit #(.DATA_WIDTH(32)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    pcu_checker #(.DATA_WIDTH(32)) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_ok_count       (ok_count),
        .o_invalid_count  (invalid_count),
        .o_overflow_count (overflow_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QuietLimit) begin
            $display("permutation_combination_unit regression: fail");
            $finish;
        end
    end

    task automatic send_request(input logic cmd, input logic [30:0] n, input logic [30:0] k);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, k, n};
        do @(posedge clk); while (!s_tready);
        if (cmd == pcu_pkg::CMD_PERM) perm_sent++;
        else comb_sent++;
    endtask

    // hold off new transfers until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random();
        logic        cmd;
        logic [30:0] n;
        logic [30:0] k;
        int          pick;
        cmd = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 35) begin
            n = 31'($urandom_range(40, 1));
            k = 31'($urandom_range(n, 0));
        end else if (pick < 50) begin
            n = 31'($urandom_range(NMax, 1));
            k = 31'($urandom_range(3));
        end else if (pick < 65) begin
            n = 31'($urandom());
            k = 31'($urandom());
        end else if (pick < 75) begin
            n = 31'($urandom_range(NMax - 1, 0));
            k = 31'($urandom_range(NMax, n + 1));
        end else if (pick < 80) begin
            n = '0;
            k = 31'($urandom());
        end else begin
            n = 31'($urandom_range(200, 13));
            k = 31'($urandom_range(12));
        end
        send_request(cmd, n, k);
    endtask

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase = '{0, 46, 0, 22};
        stall_by_phase = '{0, 0, 46, 22};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operand extremes and the invalid, overflow and zero-k corners
        send_request(pcu_pkg::CMD_PERM, 31'd0, 31'd0);
        send_request(pcu_pkg::CMD_COMB, 31'd0, NMax);
        send_request(pcu_pkg::CMD_PERM, 31'd5, 31'd6);
        send_request(pcu_pkg::CMD_COMB, 31'd1, NMax);
        send_request(pcu_pkg::CMD_PERM, 31'd7, 31'd0);
        send_request(pcu_pkg::CMD_COMB, NMax, 31'd0);
        send_request(pcu_pkg::CMD_PERM, 31'd1, 31'd1);
        send_request(pcu_pkg::CMD_COMB, 31'd1, 31'd1);
        send_request(pcu_pkg::CMD_PERM, NMax, 31'd1);
        send_request(pcu_pkg::CMD_COMB, NMax, 31'd1);
        send_request(pcu_pkg::CMD_PERM, NMax, 31'd2);
        send_request(pcu_pkg::CMD_COMB, NMax, 31'd2);
        send_request(pcu_pkg::CMD_PERM, NMax, NMax);
        send_request(pcu_pkg::CMD_COMB, NMax, NMax);
        send_request(pcu_pkg::CMD_PERM, 31'd12, 31'd12);
        send_request(pcu_pkg::CMD_COMB, 31'd12, 31'd12);
        send_request(pcu_pkg::CMD_PERM, 31'd13, 31'd13);
        send_request(pcu_pkg::CMD_COMB, 31'd13, 31'd13);
        send_request(pcu_pkg::CMD_COMB, 31'd30, 31'd6);
        send_request(pcu_pkg::CMD_COMB, 31'd34, 31'd17);
        send_request(pcu_pkg::CMD_PERM, 31'd46341, 31'd2);
        send_request(pcu_pkg::CMD_COMB, 31'd46340, 31'd2);
        send_request(pcu_pkg::CMD_COMB, 31'h5555_5555, 31'h2AAA_AAAA);
        send_request(pcu_pkg::CMD_PERM, 31'h2AAA_AAAA, 31'h5555_5555);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            for (int i = 0; i < RandomPerPhase; i++) begin
                send_random();
            end
            drain_results();
        end

        repeat (TailCycles) @(posedge clk);
        $display("covered %0d permutation and %0d combination requests under four idle mixes",
                 perm_sent, comb_sent);
        $display("predicted status: %0d ok, %0d invalid operands, %0d overflow",
                 ok_count, invalid_count, overflow_count);
        if (fail_count == 0 && pending == 0) begin
            $display("permutation_combination_unit regression: pass");
        end else begin
            $display("permutation_combination_unit regression: fail");
        end
        $finish;
    end

endmodule
